// ===== rtl/core/omp_pkg.sv =====
`default_nettype none

// Shared types, constants and keyword tables of the order message parser.
package omp_pkg;

	// Product name characters kept from the third word.
	localparam int NAME_CHARS = 8;
	// Largest number accepted by the range checks.
	localparam int MAX_VALUE  = 999999;
	// Value that a number too large saturates to.
	localparam int SAT_VALUE  = MAX_VALUE + 1;

	// Digit accumulator, stored word number and multiply-accumulate widths.
	localparam int NUM_W = 21;
	localparam int WN_W  = NUM_W + 1;
	localparam int ACC_W = NUM_W + 4;

	// Number of stored word numbers and of keywords.
	localparam int NUM_WORDS = 4;
	localparam int KW_COUNT  = 4;

	// Port widths.
	localparam int CHAR_W      = 8;
	localparam int TRADER_W    = 16;
	localparam int VALUE_W     = 32;
	localparam int NAME_W      = 64;
	localparam int LEN_W       = 4;
	localparam int KIND_W      = 3;
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 184;

	// Saturation limits of the word counter and character position.
	localparam logic [2:0] WC_MAX  = 3'd7;
	localparam logic [2:0] POS_MAX = 3'd7;

	// Word index that holds the product name.
	localparam logic [2:0] NAME_WORD = 3'd2;

	// Characters with a meaning of their own.
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

	// Bit positions in the number scan flags.
	localparam int FLAG_SIGN  = 0;
	localparam int FLAG_MINUS = 1;
	localparam int FLAG_DIGIT = 2;
	localparam int FLAG_STOP  = 3;

	// Field value reported where a field does not apply.
	localparam logic [VALUE_W-1:0] NO_VALUE = 32'h8000_0000;

	// Record kinds; the first four double as keyword indexes.
	typedef enum logic [KIND_W-1:0] {
		KIND_BUY     = 3'd0,
		KIND_SELL    = 3'd1,
		KIND_AMEND   = 3'd2,
		KIND_CANCEL  = 3'd3,
		KIND_INVALID = 3'd4
	} kind_t;

	// Everything the record decode needs, captured at the end of a message.
	typedef struct packed {
		logic [TRADER_W-1:0]                   trader;
		logic [2:0]                            word_count;
		logic [KW_COUNT-1:0]                   kw_match;
		logic [NUM_WORDS-1:0][WN_W-1:0]        word_numbers;
		logic [NAME_W-1:0]                     name;
		logic [LEN_W-1:0]                      name_count;
	} snap_t;

	// One decoded record.
	typedef struct packed {
		logic [TRADER_W-1:0] trader;
		kind_t               kind;
		logic [VALUE_W-1:0]  order_ref;
		logic [VALUE_W-1:0]  quantity;
		logic [VALUE_W-1:0]  price;
		logic [NAME_W-1:0]   product_text;
		logic [LEN_W-1:0]    product_len;
	} rec_t;

	// Length of each keyword.
	function automatic logic [2:0] kw_len(input logic [1:0] k);
		logic [2:0] len;
		unique case (k)
			2'd0: len = 3'd3;
			2'd1: len = 3'd4;
			2'd2: len = 3'd5;
			2'd3: len = 3'd6;
			default: len = 3'd0;
		endcase
		return len;
	endfunction

	// Words that a message opening with each keyword must have.
	function automatic logic [2:0] kw_words(input logic [1:0] k);
		logic [2:0] n;
		unique case (k)
			2'd0: n = 3'd5;
			2'd1: n = 3'd5;
			2'd2: n = 3'd4;
			2'd3: n = 3'd2;
			default: n = 3'd0;
		endcase
		return n;
	endfunction

	// Character of keyword k at position pos; zero past its end.
	function automatic logic [CHAR_W-1:0] kw_char(input logic [1:0] k, input logic [2:0] pos);
		logic [CHAR_W-1:0] ch;
		ch = 8'h00;
		unique case (k)
			2'd0: begin
				unique case (pos)
					3'd0: ch = "B";
					3'd1: ch = "U";
					3'd2: ch = "Y";
					default: ch = 8'h00;
				endcase
			end
			2'd1: begin
				unique case (pos)
					3'd0: ch = "S";
					3'd1: ch = "E";
					3'd2: ch = "L";
					3'd3: ch = "L";
					default: ch = 8'h00;
				endcase
			end
			2'd2: begin
				unique case (pos)
					3'd0: ch = "A";
					3'd1: ch = "M";
					3'd2: ch = "E";
					3'd3: ch = "N";
					3'd4: ch = "D";
					default: ch = 8'h00;
				endcase
			end
			2'd3: begin
				unique case (pos)
					3'd0: ch = "C";
					3'd1: ch = "A";
					3'd2: ch = "N";
					3'd3: ch = "C";
					3'd4: ch = "E";
					3'd5: ch = "L";
					default: ch = 8'h00;
				endcase
			end
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/omp_scan.sv =====
`default_nettype none

// Character scanner: keeps the per-message state, updates it with each
// accepted character and captures a snapshot of the message on its last one.
module omp_scan (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [omp_pkg::CHAR_W-1:0]      char_in,
	input  wire logic                            last,
	input  wire logic [omp_pkg::TRADER_W-1:0]    trader_in,
	output logic                                 snap_valid,
	input  wire logic                            snap_ready,
	output omp_pkg::snap_t                       snap
);

	// Message state.
	logic [2:0]                                        word_count_q;
	logic                                              in_word_q;
	logic [2:0]                                        char_pos_q;
	logic [omp_pkg::KW_COUNT-1:0]                      kw_match_q;
	logic [omp_pkg::NUM_W-1:0]                         num_value_q;
	logic [3:0]                                        num_flags_q;
	logic [omp_pkg::NAME_W-1:0]                        name_q;
	logic [omp_pkg::LEN_W-1:0]                         name_count_q;
	logic [omp_pkg::NUM_WORDS-1:0][omp_pkg::WN_W-1:0]  word_numbers_q;

	// Snapshot register.
	logic                                              snap_valid_s1;
	omp_pkg::snap_t                                    snap_s1;

	logic                                              accept;
	logic                                              is_ws;
	logic                                              do_finish;
	logic [2:0]                                        base_pos;
	logic [omp_pkg::NUM_W-1:0]                         base_value;
	logic [3:0]                                        base_flags;
	logic [2:0]                                        t_pos;
	logic [omp_pkg::KW_COUNT-1:0]                      t_kw;
	logic [omp_pkg::NUM_W-1:0]                         t_value;
	logic [3:0]                                        t_flags;
	logic [omp_pkg::NAME_W-1:0]                        t_name;
	logic [omp_pkg::LEN_W-1:0]                         t_name_count;
	logic [omp_pkg::ACC_W-1:0]                         acc;
	logic                                              is_digit;
	logic [2:0]                                        w_pos;
	logic [omp_pkg::KW_COUNT-1:0]                      w_kw;
	logic [omp_pkg::NUM_W-1:0]                         w_value;
	logic [3:0]                                        w_flags;
	logic [omp_pkg::NAME_W-1:0]                        w_name;
	logic [omp_pkg::LEN_W-1:0]                         w_name_count;
	logic [omp_pkg::KW_COUNT-1:0]                      f_kw;
	logic [2:0]                                        f_word_count;
	logic [omp_pkg::WN_W-1:0]                          f_number;
	logic [omp_pkg::NUM_WORDS-1:0][omp_pkg::WN_W-1:0]  f_word_numbers;
	logic [2:0]                                        wn_index;

	// The scanner takes a character whenever the snapshot register can move on.
	assign in_ready = !snap_valid_s1 || snap_ready;
	assign accept   = in_valid && in_ready;

	// Whitespace is space, tab, LF, VT, FF and CR.
	assign is_ws = (char_in == omp_pkg::CH_SPACE) ||
		((char_in >= omp_pkg::CH_TAB) && (char_in <= omp_pkg::CH_CR));
	assign is_digit = (char_in >= omp_pkg::CH_ZERO) && (char_in <= omp_pkg::CH_NINE);

	// A word that starts here sees a fresh position, value and flags.
	assign base_pos   = in_word_q ? char_pos_q : 3'd0;
	assign base_value = in_word_q ? num_value_q : '0;
	assign base_flags = in_word_q ? num_flags_q : 4'd0;

	// Value times ten plus the new digit.
	assign acc = omp_pkg::ACC_W'({base_value, 3'b000}) + omp_pkg::ACC_W'({base_value, 1'b0}) +
		omp_pkg::ACC_W'(char_in[3:0]);

	// Update of the word state by a character that is not whitespace.
	always_comb begin
		t_kw         = kw_match_q;
		t_value      = base_value;
		t_flags      = base_flags;
		t_name       = name_q;
		t_name_count = name_count_q;
		t_pos        = (base_pos == omp_pkg::POS_MAX) ? omp_pkg::POS_MAX : base_pos + 3'd1;

		// Keyword match on the first word.
		if (word_count_q == 3'd0) begin
			for (int k = 0; k < omp_pkg::KW_COUNT; k++) begin
				if ((base_pos >= omp_pkg::kw_len(2'(k))) ||
					(omp_pkg::kw_char(2'(k), base_pos) != char_in)) begin
					t_kw[k] = 1'b0;
				end
			end
		end else if ((word_count_q <= 3'd4) && !base_flags[omp_pkg::FLAG_STOP]) begin
			// Number scan: optional sign first, then digits until anything else.
			if ((base_pos == 3'd0) &&
				((char_in == omp_pkg::CH_PLUS) || (char_in == omp_pkg::CH_MINUS))) begin
				t_flags[omp_pkg::FLAG_SIGN] = 1'b1;
				if (char_in == omp_pkg::CH_MINUS) begin
					t_flags[omp_pkg::FLAG_MINUS] = 1'b1;
				end
			end else if (is_digit) begin
				if (acc > omp_pkg::ACC_W'(omp_pkg::SAT_VALUE)) begin
					t_value = omp_pkg::NUM_W'(omp_pkg::SAT_VALUE);
				end else begin
					t_value = acc[omp_pkg::NUM_W-1:0];
				end
				t_flags[omp_pkg::FLAG_DIGIT] = 1'b1;
			end else begin
				t_flags[omp_pkg::FLAG_STOP] = 1'b1;
			end
		end

		// Product name characters.
		if ((word_count_q == omp_pkg::NAME_WORD) &&
			(name_count_q < omp_pkg::LEN_W'(omp_pkg::NAME_CHARS))) begin
			t_name[8*name_count_q[2:0] +: 8] = char_in;
			t_name_count = name_count_q + 4'd1;
		end
	end

	// Word state after this character, and whether the word ends here.
	assign w_pos        = is_ws ? char_pos_q   : t_pos;
	assign w_kw         = is_ws ? kw_match_q   : t_kw;
	assign w_value      = is_ws ? num_value_q  : t_value;
	assign w_flags      = is_ws ? num_flags_q  : t_flags;
	assign w_name       = is_ws ? name_q       : t_name;
	assign w_name_count = is_ws ? name_count_q : t_name_count;
	assign do_finish    = is_ws ? in_word_q    : last;

	// Number that a finished word stores.
	always_comb begin
		if (!w_flags[omp_pkg::FLAG_DIGIT]) begin
			f_number = '1;
		end else if (w_flags[omp_pkg::FLAG_MINUS] && (w_value != '0)) begin
			f_number = '1;
		end else begin
			f_number = {1'b0, w_value};
		end
	end

	assign wn_index = word_count_q - 3'd1;

	// Finishing a word: keyword length check, number store, word count.
	always_comb begin
		f_kw           = w_kw;
		f_word_numbers = word_numbers_q;
		f_word_count   = word_count_q;
		if (do_finish) begin
			if (word_count_q == 3'd0) begin
				for (int k = 0; k < omp_pkg::KW_COUNT; k++) begin
					if (w_pos != omp_pkg::kw_len(2'(k))) begin
						f_kw[k] = 1'b0;
					end
				end
			end else if (word_count_q <= 3'd4) begin
				f_word_numbers[wn_index[1:0]] = f_number;
			end
			if (word_count_q != omp_pkg::WC_MAX) begin
				f_word_count = word_count_q + 3'd1;
			end
		end
	end

	// Message state; everything returns to its reset value after the last character.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_count_q <= 3'd0;
			in_word_q    <= 1'b0;
			char_pos_q   <= 3'd0;
			kw_match_q   <= '1;
			num_value_q  <= '0;
			num_flags_q  <= 4'd0;
			name_q       <= '0;
			name_count_q <= '0;
		end else if (accept) begin
			if (last) begin
				word_count_q <= 3'd0;
				in_word_q    <= 1'b0;
				char_pos_q   <= 3'd0;
				kw_match_q   <= '1;
				num_value_q  <= '0;
				num_flags_q  <= 4'd0;
				name_q       <= '0;
				name_count_q <= '0;
			end else begin
				word_count_q <= f_word_count;
				in_word_q    <= !is_ws;
				char_pos_q   <= w_pos;
				kw_match_q   <= f_kw;
				num_value_q  <= w_value;
				num_flags_q  <= w_flags;
				name_q       <= w_name;
				name_count_q <= w_name_count;
			end
		end
	end

	// Stored word numbers are only read once written in the same message.
	always_ff @(posedge clk) begin
		if (accept) begin
			word_numbers_q <= f_word_numbers;
		end
	end

	// Snapshot register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			snap_valid_s1 <= accept && last;
		end
	end

	// Snapshot payload.
	always_ff @(posedge clk) begin
		if (accept && last) begin
			snap_s1.trader       <= trader_in;
			snap_s1.word_count   <= f_word_count;
			snap_s1.kw_match     <= f_kw;
			snap_s1.word_numbers <= f_word_numbers;
			snap_s1.name         <= w_name;
			snap_s1.name_count   <= w_name_count;
		end
	end

	assign snap_valid = snap_valid_s1;
	assign snap       = snap_s1;

endmodule

`default_nettype wire

// ===== rtl/core/omp_record.sv =====
`default_nettype none

// Record decode: keyword and word count check, field selection, range
// checks, and the output register.
module omp_record (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              snap_valid,
	output logic                   snap_ready,
	input  wire omp_pkg::snap_t    snap,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output omp_pkg::rec_t          rec
);

	localparam logic signed [omp_pkg::WN_W-1:0] MaxWn = omp_pkg::WN_W'(omp_pkg::MAX_VALUE);

	logic                          out_valid_q;
	omp_pkg::rec_t                 rec_q;
	omp_pkg::kind_t                kw_kind;
	omp_pkg::kind_t                kind;
	logic signed [omp_pkg::WN_W-1:0] oid;
	logic signed [omp_pkg::WN_W-1:0] qty;
	logic signed [omp_pkg::WN_W-1:0] prc;
	logic                          oid_ok;
	logic                          qty_ok;
	logic                          prc_ok;
	omp_pkg::rec_t                 rec_d;

	assign snap_ready = !out_valid_q || out_ready;

	// First keyword whose text and word count both match.
	always_comb begin
		kw_kind = omp_pkg::KIND_INVALID;
		for (int k = omp_pkg::KW_COUNT - 1; k >= 0; k--) begin
			if (snap.kw_match[k] && (snap.word_count == omp_pkg::kw_words(2'(k)))) begin
				kw_kind = omp_pkg::kind_t'(3'(k));
			end
		end
	end

	assign oid = snap.word_numbers[0];
	assign qty = (kw_kind == omp_pkg::KIND_AMEND) ? snap.word_numbers[1] : snap.word_numbers[2];
	assign prc = (kw_kind == omp_pkg::KIND_AMEND) ? snap.word_numbers[2] : snap.word_numbers[3];

	assign oid_ok = (oid >= 0) && (oid <= MaxWn);
	assign qty_ok = (qty >= 1) && (qty <= MaxWn);
	assign prc_ok = (prc >= 1) && (prc <= MaxWn);

	// Range checks turn a well-formed message into an invalid record.
	always_comb begin
		unique case (kw_kind)
			omp_pkg::KIND_BUY, omp_pkg::KIND_SELL, omp_pkg::KIND_AMEND:
				kind = (oid_ok && qty_ok && prc_ok) ? kw_kind : omp_pkg::KIND_INVALID;
			omp_pkg::KIND_CANCEL:
				kind = oid_ok ? kw_kind : omp_pkg::KIND_INVALID;
			default:
				kind = omp_pkg::KIND_INVALID;
		endcase
	end

	// Fields reported follow the keyword, not the range check.
	always_comb begin
		rec_d.trader       = snap.trader;
		rec_d.kind         = kind;
		rec_d.order_ref    = omp_pkg::NO_VALUE;
		rec_d.quantity     = omp_pkg::NO_VALUE;
		rec_d.price        = omp_pkg::NO_VALUE;
		rec_d.product_text = '0;
		rec_d.product_len  = '0;
		if (kw_kind != omp_pkg::KIND_INVALID) begin
			rec_d.order_ref = {{(omp_pkg::VALUE_W-omp_pkg::WN_W){oid[omp_pkg::WN_W-1]}}, oid};
		end
		if ((kw_kind == omp_pkg::KIND_BUY) || (kw_kind == omp_pkg::KIND_SELL) ||
			(kw_kind == omp_pkg::KIND_AMEND)) begin
			rec_d.quantity = {{(omp_pkg::VALUE_W-omp_pkg::WN_W){qty[omp_pkg::WN_W-1]}}, qty};
			rec_d.price    = {{(omp_pkg::VALUE_W-omp_pkg::WN_W){prc[omp_pkg::WN_W-1]}}, prc};
		end
		if ((kw_kind == omp_pkg::KIND_BUY) || (kw_kind == omp_pkg::KIND_SELL)) begin
			rec_d.product_text = snap.name;
			rec_d.product_len  = snap.name_count;
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (snap_ready) begin
			out_valid_q <= snap_valid;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (snap_valid && snap_ready) begin
			rec_q <= rec_d;
		end
	end

	assign out_valid = out_valid_q;
	assign rec       = rec_q;

endmodule

`default_nettype wire

// ===== rtl/core/order_message_parser.sv =====
// Order message parser. Characters of an order message stream in, one per
// transfer and one per cycle at full rate; the transfer with tlast set ends the
// message, and its decoded record passes the snapshot register, then the output register.
// The block has two record registers (a message snapshot and the output
// register), so the input keeps taking characters while a record waits to be
// taken and drops tready only when both hold an untaken record. Words are split
// on any whitespace, the first word selects BUY, SELL, AMEND or CANCEL, and the
// numbers in the following words are read in decimal with an optional sign,
// saturating above 999999; out-of-range fields mark the record invalid.
`default_nettype none

module order_message_parser (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_axis_tvalid,
	output logic                                    s_axis_tready,
	// char_in [7:0], trader_in [23:8]
	input  wire logic [omp_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	input  wire logic                               s_axis_tlast,
	output logic                                    m_axis_tvalid,
	input  wire logic                               m_axis_tready,
	// trader_out [15:0], order_ref [47:16], quantity [79:48], price [111:80],
	// product_text [175:112], product_len [179:176], zero [183:180]
	output logic [omp_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
	// kind [2:0]
	output logic [omp_pkg::KIND_W-1:0]              m_axis_tuser
);

	logic              snap_valid;
	logic              snap_ready;
	omp_pkg::snap_t    snap;
	omp_pkg::rec_t     rec;

	// Character scanner and message snapshot.
	omp_scan u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.char_in    (s_axis_tdata[omp_pkg::CHAR_W-1:0]),
		.last       (s_axis_tlast),
		.trader_in  (s_axis_tdata[omp_pkg::CHAR_W +: omp_pkg::TRADER_W]),
		.snap_valid (snap_valid),
		.snap_ready (snap_ready),
		.snap       (snap)
	);

	// Record decode and output register.
	omp_record u_record (
		.clk        (clk),
		.arst_n     (arst_n),
		.snap_valid (snap_valid),
		.snap_ready (snap_ready),
		.snap       (snap),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.rec        (rec)
	);

	// Pack the record fields, lowest field first.
	assign m_axis_tdata = {4'b0000, rec.product_len, rec.product_text, rec.price,
		rec.quantity, rec.order_ref, rec.trader};
	assign m_axis_tuser = rec.kind;

endmodule

`default_nettype wire

// ===== rtl/core/omp_checker.sv =====
`default_nettype none

// Port-level checks of the order message parser.
module omp_checker (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_axis_tvalid,
	input  wire logic                               s_axis_tready,
	input  wire logic                               m_axis_tvalid,
	input  wire logic                               m_axis_tready,
	input  wire logic [omp_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	input  wire logic [omp_pkg::KIND_W-1:0]         m_axis_tuser
);

	// The input is held off only while a record waits on a stalled output.
	a_ready_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
		else $error("input stalled without a waiting record");

	// A record offered and not taken stays unchanged.
	a_record_held: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=>
			(m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
		else $error("stalled record changed");

	// A cancel record carries no quantity, price or product.
	a_cancel_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tuser == omp_pkg::KIND_CANCEL)) |->
			((m_axis_tdata[79:48] == omp_pkg::NO_VALUE) &&
			 (m_axis_tdata[111:80] == omp_pkg::NO_VALUE) &&
			 (m_axis_tdata[179:176] == 4'd0)))
		else $error("cancel record with order fields");

	// A valid record has an order reference inside the accepted range.
	a_valid_order_ref: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tuser != omp_pkg::KIND_INVALID)) |->
			(!m_axis_tdata[47] &&
			 (m_axis_tdata[47:16] <= omp_pkg::VALUE_W'(omp_pkg::MAX_VALUE))))
		else $error("order reference out of range on a valid record");

endmodule

bind order_message_parser omp_checker u_omp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import omp_pkg::*;

	// One character transfer waiting to be offered to the parser.
	typedef struct {
		logic [CHAR_W-1:0]   ch;
		bit                  eom;
		logic [TRADER_W-1:0] trader;
	} char_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	// char_in [7:0], trader_in [23:8]
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                   s_axis_tlast = 1'b0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	// trader_out [15:0], order_ref [47:16], quantity [79:48], price [111:80],
	// product_text [175:112], product_len [179:176], zero [183:180]
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	// kind [2:0]
	logic [KIND_W-1:0]      m_axis_tuser;

	char_item_t   chars_to_send[$];
	rec_t         records_due[$];
	logic [7:0]   msg_buf[$];
	int           chars_made = 0;
	int           send_idle_pct = 0;
	int           recv_stall_pct = 0;
	int           hold_left = 0;
	int           mismatches = 0;
	bit           char_taken = 1'b0;

	// Parser state as the prediction sees it.
	logic [2:0]          msg_words = '0;
	bit                  in_word = 1'b0;
	logic [2:0]          word_pos = '0;
	logic [KW_COUNT-1:0] kw_alive = '1;
	int                  num_acc = 0;
	bit                  num_minus = 1'b0;
	bit                  num_digit = 1'b0;
	bit                  num_stop = 1'b0;
	int                  word_value[NUM_WORDS];
	logic [NAME_W-1:0]   name_bytes = '0;
	logic [LEN_W-1:0]    name_len = '0;

	order_message_parser u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #10 clk = ~clk;

	// Keyword spelling and the word count that each keyword demands.
	function automatic string keyword_text(input kind_t k);
		case (k)
			KIND_BUY:    return "BUY";
			KIND_SELL:   return "SELL";
			KIND_AMEND:  return "AMEND";
			KIND_CANCEL: return "CANCEL";
			default:     return "";
		endcase
	endfunction

	function automatic int keyword_word_count(input kind_t k);
		case (k)
			KIND_BUY:    return 5;
			KIND_SELL:   return 5;
			KIND_AMEND:  return 4;
			KIND_CANCEL: return 2;
			default:     return 0;
		endcase
	endfunction

	function automatic bit is_blank(input logic [7:0] c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic bit in_limits(input int v, input int lo);
		return v >= lo && v <= MAX_VALUE;
	endfunction

	function automatic void clear_message();
		msg_words = '0;
		in_word = 1'b0;
		word_pos = '0;
		kw_alive = '1;
		num_acc = 0;
		num_minus = 1'b0;
		num_digit = 1'b0;
		num_stop = 1'b0;
		name_bytes = '0;
		name_len = '0;
	endfunction

	// End of a word: settle the keyword match or store the number read.
	function automatic void close_word();
		int k;
		string kw;
		if (msg_words == 0) begin
			for (k = 0; k < KW_COUNT; k++) begin
				kw = keyword_text(kind_t'(k));
				if (word_pos != kw.len())
					kw_alive[k] = 1'b0;
			end
		end else if (msg_words <= NUM_WORDS) begin
			if (!num_digit)
				word_value[msg_words - 1] = -1;
			else if (num_minus && num_acc != 0)
				word_value[msg_words - 1] = -1;
			else
				word_value[msg_words - 1] = num_acc;
		end
		if (msg_words != WC_MAX)
			msg_words = msg_words + 1'b1;
		in_word = 1'b0;
	endfunction

	// A character that is part of a word.
	function automatic void take_char(input logic [7:0] c);
		int k;
		string kw;
		if (!in_word) begin
			in_word = 1'b1;
			word_pos = '0;
			num_acc = 0;
			num_minus = 1'b0;
			num_digit = 1'b0;
			num_stop = 1'b0;
		end
		if (msg_words == 0) begin
			for (k = 0; k < KW_COUNT; k++) begin
				kw = keyword_text(kind_t'(k));
				if (word_pos >= kw.len() || kw[word_pos] != c)
					kw_alive[k] = 1'b0;
			end
		end else if (msg_words <= NUM_WORDS && !num_stop) begin
			if (word_pos == 0 && (c == CH_PLUS || c == CH_MINUS)) begin
				if (c == CH_MINUS)
					num_minus = 1'b1;
			end else if (c >= CH_ZERO && c <= CH_NINE) begin
				num_acc = num_acc * 10 + (c - CH_ZERO);
				if (num_acc > SAT_VALUE)
					num_acc = SAT_VALUE;
				num_digit = 1'b1;
			end else begin
				num_stop = 1'b1;
			end
		end
		if (msg_words == NAME_WORD && name_len < NAME_CHARS) begin
			name_bytes[8 * name_len +: 8] = c;
			name_len = name_len + 1'b1;
		end
		if (word_pos != POS_MAX)
			word_pos = word_pos + 1'b1;
	endfunction

	// Advances the parser prediction by one character and queues the record
	// that the final character of a message produces.
	function automatic void parse_char(input logic [7:0] c, input bit eom,
			input logic [TRADER_W-1:0] trader);
		rec_t  rec;
		kind_t kd;
		int    k;
		int    oid;
		int    qty;
		int    prc;
		if (is_blank(c)) begin
			if (in_word)
				close_word();
		end else begin
			take_char(c);
		end
		if (eom) begin
			if (in_word)
				close_word();
			kd = KIND_INVALID;
			for (k = 0; k < KW_COUNT; k++) begin
				if (kd == KIND_INVALID && kw_alive[k] &&
						msg_words == keyword_word_count(kind_t'(k)))
					kd = kind_t'(k);
			end
			oid = NO_VALUE;
			qty = NO_VALUE;
			prc = NO_VALUE;
			rec.product_text = '0;
			rec.product_len = '0;
			if (kd != KIND_INVALID)
				oid = word_value[0];
			if (kd == KIND_BUY || kd == KIND_SELL) begin
				rec.product_text = name_bytes;
				rec.product_len = name_len;
				qty = word_value[2];
				prc = word_value[3];
			end else if (kd == KIND_AMEND) begin
				qty = word_value[1];
				prc = word_value[2];
			end
			if (kd == KIND_CANCEL) begin
				if (!in_limits(oid, 0))
					kd = KIND_INVALID;
			end else if (kd != KIND_INVALID) begin
				if (!in_limits(oid, 0) || !in_limits(qty, 1) || !in_limits(prc, 1))
					kd = KIND_INVALID;
			end
			rec.trader = trader;
			rec.kind = kd;
			rec.order_ref = oid;
			rec.quantity = qty;
			rec.price = prc;
			records_due.push_back(rec);
			clear_message();
		end
	endfunction

	// Prints one line for a field that differs and counts it.
	task automatic compare_field(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want) begin
			$display("%0t: %s mismatch, got %h, expected %h", $time, what, got, want);
			mismatches++;
		end
	endtask

	// Message building.
	function automatic void add_char(input logic [7:0] c);
		msg_buf.push_back(c);
	endfunction

	function automatic void add_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			msg_buf.push_back(s[i]);
	endfunction

	function automatic logic [7:0] rand_blank();
		int r;
		r = $urandom_range(11, 0);
		if (r > 4)
			return CH_SPACE;
		return CH_TAB + r[7:0];
	endfunction

	function automatic logic [7:0] rand_word_char();
		logic [7:0] c;
		if ($urandom_range(3, 0) == 0)
			c = 8'($urandom_range(255, 0));
		else
			c = 8'($urandom_range(90, 33));
		while (is_blank(c))
			c = 8'($urandom_range(255, 0));
		return c;
	endfunction

	function automatic void add_gap();
		int n;
		int i;
		n = ($urandom_range(3, 0) == 0) ? $urandom_range(3, 1) : 1;
		for (i = 0; i < n; i++)
			add_char(rand_blank());
	endfunction

	function automatic void add_name();
		int n;
		int i;
		n = $urandom_range(12, 1);
		for (i = 0; i < n; i++)
			add_char(rand_word_char());
	endfunction

	function automatic void add_digits(input int n);
		int i;
		for (i = 0; i < n; i++)
			add_char(CH_ZERO + 8'($urandom_range(9, 0)));
	endfunction

	// Leading digit of an oversized number.
	function automatic logic [7:0] CH_ONE_OR_NINE();
		return $urandom_range(1, 0) ? CH_NINE : (CH_ZERO + 1'b1);
	endfunction

	// A number word; a good one lies in lo..MAX_VALUE, a bad one trips one of
	// the sign, saturation, no-digit or junk cases.
	function automatic void add_number(input bit good, input int lo);
		int v;
		if (good) begin
			case ($urandom_range(3, 0))
				0: v = $urandom_range(9, lo);
				1: v = $urandom_range(999, lo);
				2: v = $urandom_range(MAX_VALUE, lo);
				default: v = $urandom_range(1, 0) ? MAX_VALUE : lo;
			endcase
			case ($urandom_range(9, 0))
				0: add_char(CH_PLUS);
				1: add_char(CH_ZERO);
				default: ;
			endcase
			add_text($sformatf("%0d", v));
		end else begin
			case ($urandom_range(7, 0))
				0: add_text($sformatf("-%0d", $urandom_range(MAX_VALUE, 1)));
				1: begin
					add_char(CH_MINUS);
					add_digits($urandom_range(3, 1) - 1);
					add_char(CH_ZERO);
				end
				2: begin
					add_char(CH_ONE_OR_NINE());
					add_digits($urandom_range(12, 6));
				end
				3: add_text($urandom_range(1, 0) ? "1000000" : "9999990");
				4: begin
					case ($urandom_range(2, 0))
						0: add_char(CH_PLUS);
						1: add_char(CH_MINUS);
						default: add_text("x");
					endcase
				end
				5: begin
					add_text($sformatf("%0d", $urandom_range(MAX_VALUE, 0)));
					add_char(rand_word_char());
					add_digits($urandom_range(2, 0));
				end
				6: add_char(CH_ZERO);
				default: add_name();
			endcase
		end
	endfunction

	// A keyword, possibly spoilt by a dropped, added, lowered or changed letter.
	function automatic void add_keyword(input kind_t k, input bit spoil);
		string s;
		int    i;
		int    at;
		s = keyword_text(k);
		if (!spoil) begin
			add_text(s);
		end else begin
			at = $urandom_range(s.len() - 1, 0);
			case ($urandom_range(3, 0))
				0: for (i = 0; i < s.len() - 1; i++) add_char(s[i]);
				1: begin
					add_text(s);
					add_char(rand_word_char());
				end
				2: for (i = 0; i < s.len(); i++) add_char(i == at ? (s[i] | 8'h20) : s[i]);
				default: for (i = 0; i < s.len(); i++) add_char(i == at ? rand_word_char() : s[i]);
			endcase
		end
	endfunction

	// Moves the built message to the send queue, marking its final character.
	function automatic void end_message();
		char_item_t it;
		int         i;
		for (i = 0; i < msg_buf.size(); i++) begin
			it.ch = msg_buf[i];
			it.eom = (i == msg_buf.size() - 1);
			it.trader = 16'($urandom_range(16'hFFFF, 0));
			chars_to_send.push_back(it);
		end
		chars_made += msg_buf.size();
		msg_buf.delete();
	endfunction

	// Mostly well-formed orders with random content; the rest is noise.
	function automatic void gen_message();
		kind_t k;
		int    words;
		int    i;
		if ($urandom_range(4, 0) == 0)
			add_gap();
		if ($urandom_range(9, 0) < 8) begin
			k = kind_t'($urandom_range(3, 0));
			add_keyword(k, $urandom_range(19, 0) == 0);
			words = keyword_word_count(k);
			if ($urandom_range(9, 0) == 0) begin
				if ($urandom_range(1, 0))
					words++;
				else
					words--;
			end
			for (i = 1; i < words; i++) begin
				add_gap();
				if ((k == KIND_BUY || k == KIND_SELL) && i == NAME_WORD)
					add_name();
				else
					add_number($urandom_range(5, 0) != 0, (i == 1) ? 0 : 1);
			end
		end else begin
			words = $urandom_range(9, 0);
			for (i = 0; i < words; i++) begin
				if (i != 0)
					add_gap();
				case ($urandom_range(2, 0))
					0: add_keyword(kind_t'($urandom_range(3, 0)), 1'b0);
					1: add_number($urandom_range(1, 0), 0);
					default: add_name();
				endcase
			end
		end
		if ($urandom_range(9, 0) < 3 || msg_buf.size() == 0)
			add_gap();
		end_message();
	endfunction

	task automatic run_phase(input int send_pct, input int recv_pct, input int char_target);
		int start;
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		start = chars_made;
		while (chars_made - start < char_target)
			gen_message();
		while (chars_to_send.size() != 0)
			@(posedge clk);
	endtask

	// Sender: offers the next character at the falling edge, holding an offer
	// until its transfer has happened.
	always @(negedge clk) begin
		if (!(s_axis_tvalid && !char_taken)) begin
			if (chars_to_send.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= {chars_to_send[0].trader, chars_to_send[0].ch};
				s_axis_tlast <= chars_to_send[0].eom;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, or a long hold-off while one is counting down.
	always @(negedge clk) begin
		if (hold_left != 0) begin
			m_axis_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			m_axis_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
		end
	end

	// Input side: every character transfer feeds the prediction.
	always @(posedge clk) begin
		char_taken = s_axis_tvalid && s_axis_tready;
		if (char_taken) begin
			parse_char(s_axis_tdata[CHAR_W-1:0], s_axis_tlast,
				s_axis_tdata[CHAR_W +: TRADER_W]);
			void'(chars_to_send.pop_front());
		end
	end

	// Output side: every record transfer is checked against the oldest prediction.
	always @(posedge clk) begin : record_check
		rec_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (records_due.size() == 0) begin
				compare_field("record with none expected", 64'd1, 64'd0);
			end else begin
				want = records_due.pop_front();
				compare_field("trader", 64'(m_axis_tdata[15:0]), 64'(want.trader));
				compare_field("kind", 64'(m_axis_tuser), 64'(want.kind));
				compare_field("order ref", 64'(m_axis_tdata[47:16]), 64'(want.order_ref));
				compare_field("quantity", 64'(m_axis_tdata[79:48]), 64'(want.quantity));
				compare_field("price", 64'(m_axis_tdata[111:80]), 64'(want.price));
				compare_field("product text", m_axis_tdata[175:112], want.product_text);
				compare_field("product length", 64'(m_axis_tdata[179:176]),
					64'(want.product_len));
				compare_field("padding", 64'(m_axis_tdata[183:180]), 64'd0);
			end
		end
	end

	// Stimulus: directed messages, then random phases with varied idling.
	initial begin
		clear_message();
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		add_text("BUY 0 WIDGET 1 999999");
		end_message();
		add_text("SELL 999999 LONGPRODUCT +999999 1");
		end_message();
		add_text("AMEND 17 -0 +5");
		end_message();
		add_text("CANCEL 999999");
		end_message();
		add_text("CANCEL -12");
		end_message();
		add_text("BUY 7 AB x 12345678");
		end_message();
		add_text("\t SELL\v3\fN\n4 5 ");
		add_char(CH_CR);
		end_message();
		add_text(" \t ");
		end_message();
		add_text("A B C D E F G H I J");
		end_message();
		add_text("BUYS 1 A 1 1");
		end_message();
		add_text("CANCEL 1 2");
		end_message();
		add_text("SELL 12x ");
		add_char(8'h00);
		add_char(8'hFF);
		add_char(8'h80);
		add_text(" 5 6");
		end_message();
		add_text("AMEND - 3 4");
		end_message();
		add_text("X");
		end_message();
		while (chars_to_send.size() != 0)
			@(posedge clk);

		run_phase(0, 0, 110);
		run_phase(75, 0, 110);
		run_phase(0, 75, 110);
		run_phase(29, 29, 110);

		// The receiver holds off long enough for both record registers to fill
		// and the parser to refuse characters.
		@(posedge clk);
		hold_left = 400;
		run_phase(0, 0, 110);

		while (records_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("[order_message_parser] OK");
		else
			$display("[order_message_parser] ERROR");
		$finish;
	end

	// Watchdog.
	initial begin
		#10_000_000;
		$display("[order_message_parser] ERROR");
		$finish;
	end

endmodule
